// ----- rtl/core/ilb_pkg.sv -----
package ilb_pkg;

   localparam int CAPACITY      = 16;
   localparam int ELEMENT_WIDTH = 32;

   localparam int CMD_W    = 3;
   localparam int INDEX_W  = 4;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int LENGTH_W = 5;

   // count must hold CAPACITY itself
   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W   = (COUNT_W > INDEX_W) ? COUNT_W : INDEX_W;

   localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SWAP   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [INDEX_W-1:0] index;
      logic [DATA_W-1:0]  data_in;
   } ilb_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   data_out;
      logic [LENGTH_W-1:0] length;
   } ilb_rsp_type;

   // per-cell controls, decoded once per cycle by the top level
   typedef struct packed {
      logic load_din;
      logic shift_up;
      logic load_last;
      logic sel_index;
      logic sel_last;
   } ilb_cell_ctrl_type;

endpackage

// ----- rtl/core/ilb_cell.sv -----
module ilb_cell (
   input  logic                               clock,
   input  ilb_pkg::ilb_cell_ctrl_type         ctrl,
   input  logic [ilb_pkg::ELEMENT_WIDTH-1:0]  din,
   input  logic [ilb_pkg::ELEMENT_WIDTH-1:0]  upper_value,
   input  logic [ilb_pkg::ELEMENT_WIDTH-1:0]  last_value,
   input  logic [ilb_pkg::ELEMENT_WIDTH-1:0]  index_chain_in,
   input  logic [ilb_pkg::ELEMENT_WIDTH-1:0]  last_chain_in,
   output logic [ilb_pkg::ELEMENT_WIDTH-1:0]  value,
   output logic [ilb_pkg::ELEMENT_WIDTH-1:0]  index_chain_out,
   output logic [ilb_pkg::ELEMENT_WIDTH-1:0]  last_chain_out
);
   import ilb_pkg::*;

   logic [ELEMENT_WIDTH-1:0] value_ff;
   logic [ELEMENT_WIDTH-1:0] value_in;

   always_comb begin
      if (ctrl.load_din) begin
         value_in = din;
      end else if (ctrl.shift_up) begin
         value_in = upper_value;
      end else if (ctrl.load_last) begin
         value_in = last_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   // selects are one-hot along the row, so the chains simply OR through
   assign index_chain_out = index_chain_in | (ctrl.sel_index ? value_ff : '0);
   assign last_chain_out  = last_chain_in  | (ctrl.sel_last  ? value_ff : '0);
   assign value           = value_ff;

endmodule

// ----- rtl/core/indexed_list_buffer.sv -----
// Channel   Ports                     Handshake
// command   start, busy, req_data     taken when start && !busy
// result    rsp_valid, rsp_data       one-cycle strobe, no back-pressure
//
// One command per cycle: busy stays low, every command finishes in the
// cycle it is taken and its result word appears on the following cycle.
// The row of cells shifts, loads or swaps in that same cycle; reads ripple
// along the row through OR chains. Reset clears the length and the strobe;
// cell contents stay undefined until written. The receiver cannot stall.
module indexed_list_buffer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ilb_pkg::ilb_req_type req_data,
   output logic                 rsp_valid,
   output ilb_pkg::ilb_rsp_type rsp_data
);
   import ilb_pkg::*;

   logic accept;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               rsp_valid_ff;
   ilb_rsp_type        rsp_ff;
   ilb_rsp_type        rsp_in;

   logic [CMP_W-1:0] idx_cmp;
   logic [CMP_W-1:0] cnt_cmp;
   logic index_ok, push_ok, get_ok, pop_ok, remove_ok, swap_ok;

   logic [ELEMENT_WIDTH-1:0] din;
   logic [ELEMENT_WIDTH-1:0] cell_value  [CAPACITY];
   logic [ELEMENT_WIDTH-1:0] index_chain [CAPACITY+1];
   logic [ELEMENT_WIDTH-1:0] last_chain  [CAPACITY+1];
   ilb_cell_ctrl_type        cell_ctrl   [CAPACITY];

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign idx_cmp = CMP_W'(req_data.index);
   assign cnt_cmp = CMP_W'(count_ff);
   assign din     = ELEMENT_WIDTH'(req_data.data_in);

   assign index_ok  = idx_cmp < cnt_cmp;
   assign push_ok   = accept && (req_data.command == CMD_PUSH) && (cnt_cmp < CMP_W'(CAPACITY));
   assign get_ok    = accept && (req_data.command == CMD_GET) && index_ok;
   assign pop_ok    = accept && (req_data.command == CMD_POP) && (count_ff != '0);
   assign remove_ok = accept && (req_data.command == CMD_REMOVE) && index_ok;
   assign swap_ok   = accept && (req_data.command == CMD_SWAP) && index_ok;

   assign index_chain[0] = '0;
   assign last_chain[0]  = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ELEMENT_WIDTH-1:0] upper;

      if (i == CAPACITY - 1) begin : g_top
         assign upper = '0;
      end else begin : g_mid
         assign upper = cell_value[i+1];
      end

      always_comb begin
         cell_ctrl[i].load_din  = push_ok && (cnt_cmp == CMP_W'(i));
         cell_ctrl[i].shift_up  = remove_ok && (CMP_W'(i) >= idx_cmp)
                                  && (CMP_W'(i + 1) < cnt_cmp);
         cell_ctrl[i].load_last = swap_ok && (CMP_W'(i) == idx_cmp);
         cell_ctrl[i].sel_index = CMP_W'(i) == idx_cmp;
         cell_ctrl[i].sel_last  = CMP_W'(i + 1) == cnt_cmp;
      end

      ilb_cell u_cell (
         .clock           (clock),
         .ctrl            (cell_ctrl[i]),
         .din             (din),
         .upper_value     (upper),
         .last_value      (last_chain[CAPACITY]),
         .index_chain_in  (index_chain[i]),
         .last_chain_in   (last_chain[i]),
         .value           (cell_value[i]),
         .index_chain_out (index_chain[i+1]),
         .last_chain_out  (last_chain[i+1])
      );
   end

   always_comb begin
      count_in        = count_ff;
      rsp_in.status   = ST_DONE;
      rsp_in.data_out = '0;
      unique case (req_data.command)
         CMD_PUSH: begin
            if (push_ok) begin
               count_in = count_ff + 1'b1;
            end else begin
               rsp_in.status = ST_FULL;
            end
         end
         CMD_GET: begin
            if (get_ok) begin
               rsp_in.data_out = DATA_W'(index_chain[CAPACITY]);
            end else begin
               rsp_in.status = ST_RANGE;
            end
         end
         CMD_POP: begin
            if (pop_ok) begin
               count_in        = count_ff - 1'b1;
               rsp_in.data_out = DATA_W'(last_chain[CAPACITY]);
            end else begin
               rsp_in.status = ST_RANGE;
            end
         end
         CMD_REMOVE, CMD_SWAP: begin
            if (remove_ok || swap_ok) begin
               count_in        = count_ff - 1'b1;
               rsp_in.data_out = DATA_W'(index_chain[CAPACITY]);
            end else begin
               rsp_in.status = ST_RANGE;
            end
         end
         CMD_CLEAR: begin
            if (accept) begin
               count_in = '0;
            end
         end
         default: begin
            rsp_in.status = ST_RANGE;
         end
      endcase
      rsp_in.length = LENGTH_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(CAPACITY))
      else $error("length beyond capacity");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("command without result word");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("result word without command");

   a_length_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.length == LENGTH_W'(count_ff)))
      else $error("reported length differs from stored count");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ST_DONE)) |-> (rsp_data.data_out == '0))
      else $error("error result carries data");

endmodule
